@@ rtl/uchid_pkg.sv @@
// Shared constants and types for the USB configuration HID interface scanner.
package uchid_pkg;

   localparam int HID_SLOTS_DEFAULT      = 4;
   localparam int MAX_DESC_BYTES_DEFAULT = 512;
   localparam int MASK_W                 = 4;
   localparam int LEN_W                  = 16;

   localparam logic [7:0] TYPE_INTERFACE = 8'h04;
   localparam logic [7:0] TYPE_HID       = 8'h21;
   localparam logic [7:0] CLASS_HID      = 8'h03;
   localparam logic [7:0] NO_INTERFACE   = 8'hFF;
   localparam int         MIN_CFG_LEN    = 9;

   // byte offsets inside one sub-descriptor
   localparam logic [7:0] OFS_TYPE       = 8'd1;
   localparam logic [7:0] OFS_ITF_NUMBER = 8'd2;
   localparam logic [7:0] OFS_ITF_CLASS  = 8'd5;
   localparam logic [7:0] OFS_LEN_LOW    = 8'd7;
   localparam logic [7:0] OFS_LEN_HIGH   = 8'd8;

   typedef struct packed {
      logic [MASK_W-1:0] mask;
      logic              shorty;
   } run_info_type;

   typedef struct packed {
      logic busy;
   } emit_status_type;

endpackage

@@ rtl/uchid_walker.sv @@
// Descriptor walker: per-byte state update and end-of-run summary.
module uchid_walker #(
   parameter int HID_SLOTS      = uchid_pkg::HID_SLOTS_DEFAULT,
   parameter int MAX_DESC_BYTES = uchid_pkg::MAX_DESC_BYTES_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  logic [7:0]                   data_byte,
   input  logic                         final_byte,
   output uchid_pkg::run_info_type      snap_info,
   output logic [uchid_pkg::LEN_W-1:0]  snap_lengths [(HID_SLOTS < 4) ? HID_SLOTS : 4]
);
   import uchid_pkg::*;

   localparam int NUM_SLOTS = (HID_SLOTS < 4) ? HID_SLOTS : 4;
   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int CNT_W     = $clog2(MAX_DESC_BYTES + 1);

   logic [CNT_W-1:0]     count_ff, count_in;
   logic [7:0]           offset_ff, offset_in;
   logic [7:0]           dlen_ff, dlen_in;
   logic [7:0]           dtype_ff, dtype_in;
   logic [7:0]           itf_num_ff, itf_num_in;
   logic [7:0]           itf_class_ff, itf_class_in;
   logic [7:0]           len_low_ff, len_low_in;
   logic [7:0]           cur_itf_ff, cur_itf_in;
   logic [NUM_SLOTS-1:0] mask_ff, mask_in;
   logic [LEN_W-1:0]     lengths_ff [NUM_SLOTS];
   logic [LEN_W-1:0]     lengths_in [NUM_SLOTS];
   logic                 stopped_ff, stopped_in;
   logic [7:0]           offset_next;

   always_comb begin
      count_in     = count_ff;
      offset_in    = offset_ff;
      dlen_in      = dlen_ff;
      dtype_in     = dtype_ff;
      itf_num_in   = itf_num_ff;
      itf_class_in = itf_class_ff;
      len_low_in   = len_low_ff;
      cur_itf_in   = cur_itf_ff;
      mask_in      = mask_ff;
      lengths_in   = lengths_ff;
      stopped_in   = stopped_ff;
      offset_next  = offset_ff + 8'd1;
      if (count_ff < CNT_W'(MAX_DESC_BYTES)) begin
         count_in = count_ff + CNT_W'(1);
         if (!stopped_ff) begin
            if (offset_ff == 8'd0) begin
               // length byte opens a new sub-descriptor
               dlen_in = data_byte;
               if (data_byte == 8'd0) begin
                  stopped_in = 1'b1;
               end else if (data_byte != 8'd1) begin
                  offset_in = 8'd1;
               end
            end else begin
               case (offset_ff)
                  OFS_TYPE:       dtype_in     = data_byte;
                  OFS_ITF_NUMBER: itf_num_in   = data_byte;
                  OFS_ITF_CLASS:  itf_class_in = data_byte;
                  OFS_LEN_LOW:    len_low_in   = data_byte;
                  OFS_LEN_HIGH: begin
                     if (dtype_ff == TYPE_INTERFACE) begin
                        cur_itf_in = itf_num_ff;
                        if (itf_class_ff == CLASS_HID && itf_num_ff < 8'(NUM_SLOTS)) begin
                           mask_in[itf_num_ff[SLOT_W-1:0]] = 1'b1;
                        end
                     end else if (dtype_ff == TYPE_HID && cur_itf_ff < 8'(NUM_SLOTS)) begin
                        lengths_in[cur_itf_ff[SLOT_W-1:0]] = {data_byte, len_low_ff};
                     end
                  end
                  default: ;
               endcase
               offset_in = (offset_next == dlen_ff) ? 8'd0 : offset_next;
            end
         end
      end
   end

   always_comb begin
      snap_info.mask   = MASK_W'(mask_in);
      if (mask_in == '0) begin
         snap_info.mask = MASK_W'(1);
      end
      snap_info.shorty = count_in < CNT_W'(MIN_CFG_LEN);
      snap_lengths     = lengths_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && final_byte)) begin
         count_ff     <= '0;
         offset_ff    <= '0;
         dlen_ff      <= '0;
         dtype_ff     <= '0;
         itf_num_ff   <= '0;
         itf_class_ff <= '0;
         len_low_ff   <= '0;
         cur_itf_ff   <= NO_INTERFACE;
         mask_ff      <= '0;
         stopped_ff   <= 1'b0;
         for (int i = 0; i < NUM_SLOTS; i++) begin
            lengths_ff[i] <= '0;
         end
      end else if (accept) begin
         count_ff     <= count_in;
         offset_ff    <= offset_in;
         dlen_ff      <= dlen_in;
         dtype_ff     <= dtype_in;
         itf_num_ff   <= itf_num_in;
         itf_class_ff <= itf_class_in;
         len_low_ff   <= len_low_in;
         cur_itf_ff   <= cur_itf_in;
         mask_ff      <= mask_in;
         stopped_ff   <= stopped_in;
         lengths_ff   <= lengths_in;
      end
   end

endmodule

@@ rtl/uchid_emitter.sv @@
// Result bank and output register: one slot result per transfer.
module uchid_emitter #(
   parameter int HID_SLOTS = uchid_pkg::HID_SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  uchid_pkg::run_info_type       snap_info,
   input  logic [uchid_pkg::LEN_W-1:0]   snap_lengths [(HID_SLOTS < 4) ? HID_SLOTS : 4],
   input  logic                          rsp_stall,
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_slot_index,
   output logic [uchid_pkg::LEN_W-1:0]   rsp_report_length,
   output logic                          rsp_expected,
   output logic [uchid_pkg::MASK_W-1:0]  rsp_expected_mask,
   output logic                          rsp_too_short,
   output logic                          rsp_run_end,
   output uchid_pkg::emit_status_type    status
);
   import uchid_pkg::*;

   localparam int NUM_SLOTS = (HID_SLOTS < 4) ? HID_SLOTS : 4;
   localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

   logic [LEN_W-1:0] bank_len_ff [NUM_SLOTS];
   run_info_type     bank_info_ff;
   logic             busy_ff, busy_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic             valid_ff, valid_in;
   logic [1:0]       slot_index_ff;
   logic [LEN_W-1:0] length_ff;
   logic             expected_ff;
   logic [MASK_W-1:0] mask_ff;
   logic             short_ff;
   logic             run_end_ff;
   logic             advance;
   logic             last_slot;

   assign advance   = busy_ff && (!valid_ff || !rsp_stall);
   assign last_slot = slot_ff == SLOT_W'(NUM_SLOTS - 1);

   always_comb begin
      busy_in  = busy_ff;
      slot_in  = slot_ff;
      valid_in = valid_ff;
      // drop a result once it transfers, refill if the bank has more
      if (valid_ff && !rsp_stall) begin
         valid_in = 1'b0;
      end
      if (advance) begin
         valid_in = 1'b1;
         if (last_slot) begin
            busy_in = 1'b0;
            slot_in = '0;
         end else begin
            slot_in = slot_ff + SLOT_W'(1);
         end
      end
      if (load) begin
         busy_in = 1'b1;
         slot_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         slot_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         slot_ff  <= slot_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bank_info_ff <= snap_info;
         bank_len_ff  <= snap_lengths;
      end
      if (advance) begin
         slot_index_ff <= 2'(slot_ff);
         length_ff     <= bank_info_ff.shorty ? '0 : bank_len_ff[slot_ff];
         expected_ff   <= !bank_info_ff.shorty && bank_info_ff.mask[slot_ff];
         mask_ff       <= bank_info_ff.shorty ? '0 : bank_info_ff.mask;
         short_ff      <= bank_info_ff.shorty;
         run_end_ff    <= last_slot;
      end
   end

   assign rsp_valid         = valid_ff;
   assign rsp_slot_index    = slot_index_ff;
   assign rsp_report_length = length_ff;
   assign rsp_expected      = expected_ff;
   assign rsp_expected_mask = mask_ff;
   assign rsp_too_short     = short_ff;
   assign rsp_run_end       = run_end_ff;
   assign status.busy       = busy_ff;

endmodule

@@ rtl/usb_config_hid_interface_scanner.sv @@
// Top level of the USB configuration descriptor HID interface scanner.
// Throughput: one descriptor byte per cycle while no final byte is held; the walker state
// updates at the accepting edge. The final byte of a run loads the result bank, which then
// feeds the output register one slot result per transfer, min(HID_SLOTS,4) results in all.
// A final byte waits until the previous run's last result is in the output register.
// Reset: synchronous, active high.
module usb_config_hid_interface_scanner #(
   parameter int HID_SLOTS      = uchid_pkg::HID_SLOTS_DEFAULT,
   parameter int MAX_DESC_BYTES = uchid_pkg::MAX_DESC_BYTES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_final_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_slot_index,
   output logic [uchid_pkg::LEN_W-1:0]   rsp_report_length,
   output logic                          rsp_expected,
   output logic [uchid_pkg::MASK_W-1:0]  rsp_expected_mask,
   output logic                          rsp_too_short,
   output logic                          rsp_run_end
);
   import uchid_pkg::*;

   localparam int NUM_SLOTS = (HID_SLOTS < 4) ? HID_SLOTS : 4;

   logic            req_accept;
   run_info_type    snap_info;
   logic [LEN_W-1:0] snap_lengths [NUM_SLOTS];
   emit_status_type emit_status;

   // hold a final byte until the result bank is free; ordinary bytes never wait
   assign req_stall  = emit_status.busy && req_final_byte;
   assign req_accept = req_valid && !req_stall;

   // walk the sub-descriptors; on a final transfer it hands over a summary and restarts
   uchid_walker #(
      .HID_SLOTS      (HID_SLOTS),
      .MAX_DESC_BYTES (MAX_DESC_BYTES)
   ) u_walker (
      .clock        (clock),
      .reset        (reset),
      .accept       (req_accept),
      .data_byte    (req_data_byte),
      .final_byte   (req_final_byte),
      .snap_info    (snap_info),
      .snap_lengths (snap_lengths)
   );

   // bank the summary and advance one slot per result transfer
   uchid_emitter #(
      .HID_SLOTS (HID_SLOTS)
   ) u_emitter (
      .clock             (clock),
      .reset             (reset),
      .load              (req_accept && req_final_byte),
      .snap_info         (snap_info),
      .snap_lengths      (snap_lengths),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_report_length (rsp_report_length),
      .rsp_expected      (rsp_expected),
      .rsp_expected_mask (rsp_expected_mask),
      .rsp_too_short     (rsp_too_short),
      .rsp_run_end       (rsp_run_end),
      .status            (emit_status)
   );

`ifndef SYNTH
   a_short_zeros: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_too_short |->
         rsp_report_length == '0 && !rsp_expected && rsp_expected_mask == '0)
      else $error("too-short result carries nonzero fields");

   a_mask_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_too_short |-> rsp_expected_mask != '0)
      else $error("valid run result with empty mask");

   a_final_needs_free_bank: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_final_byte && !req_stall |-> !emit_status.busy)
      else $error("final byte accepted while result bank busy");

   a_slots_follow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_run_end |=> rsp_valid)
      else $error("gap inside a run's results");
`endif

endmodule
